FILE: sv/qpr_pkg.sv
// Shared constants, number formats and the arctangent table of the quaternion point rotator.
// Used by qpr_axis_unit, qpr_half_angle and the top level. No dependencies.
`default_nettype none

package qpr_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int CORDIC_STEPS  = 20;

	localparam int DATA_W = 32;

	// Axis normalization: magnitudes, squares, root and quotient widths.
	localparam int MAG_W      = 32;
	localparam int SQ_W       = 64;
	localparam int SQRT_STEPS = 32;
	localparam int LEN_W      = 32;
	localparam int QUO_W      = 31;
	localparam int REM_W      = 1 + MAG_W + 30;
	localparam int UNIT_W     = 32;
	localparam int SHIFT_W    = 5;
	localparam int NORM_MSB   = 30;
	localparam int AXIS_LAT   = 4 + SQRT_STEPS + QUO_W + 1;

	// Half angle and CORDIC.
	localparam int TRIG_W = 33;
	localparam int Z_W    = 34;
	localparam int ANG_W  = 34;
	localparam longint MOD_DEG    = longint'(360) << FRACTION_BITS;
	localparam longint HALF_RANGE = longint'(1) << (DATA_W - 1);
	localparam longint MOD_OFS    = (HALF_RANGE + MOD_DEG - 1) / MOD_DEG * MOD_DEG;
	localparam int MOD_STEPS = $clog2((HALF_RANGE + MOD_OFS) / MOD_DEG + 1);
	localparam int ZSHL = (FRACTION_BITS <= 23) ? 23 - FRACTION_BITS : 0;
	localparam int ZSHR = (FRACTION_BITS <= 23) ? 0 : FRACTION_BITS - 23;
	localparam longint DEG90_Q24  = longint'(90) << 24;
	localparam longint DEG180_Q24 = longint'(180) << 24;
	localparam int ANGLE_LAT = MOD_STEPS + CORDIC_STEPS + 3;
	localparam int ALIGN_LAT = AXIS_LAT - ANGLE_LAT;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

	// Arctangent of 2^-i in degrees, Q.24.
	localparam logic [30:0] ATAN_DEG_Q24 [32] = '{
		31'd754974720, 31'd445687602, 31'd235489089, 31'd119537938, 31'd60000934,
		31'd30029717, 31'd15018523, 31'd7509720, 31'd3754917, 31'd1877466,
		31'd938734, 31'd469367, 31'd234684, 31'd117342, 31'd58671, 31'd29335,
		31'd14668, 31'd7334, 31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229,
		31'd115, 31'd57, 31'd29, 31'd14, 31'd7, 31'd4, 31'd2, 31'd1, 31'd0
	};

endpackage

`default_nettype wire

FILE: sv/qpr_axis_unit.sv
// Axis unit vector pipeline: magnitudes, short-axis test, normalization shift,
// a one-bit-per-stage square root and three one-bit-per-stage dividers. Uses qpr_pkg.
`default_nettype none

module qpr_axis_unit import qpr_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [DATA_W-1:0]        thr,
	input  wire logic signed [DATA_W-1:0] axis [3],
	output logic signed [UNIT_W-1:0]      unit_vec [3],
	output logic                          short_axis
);

	typedef struct packed {
		logic [SQ_W-1:0]           n;
		logic [SQ_W-1:0]           res;
		logic [2:0][MAG_W-1:0]     mk;
		logic [2:0]                neg;
		logic                      short_axis;
	} sqrt_pipe_t;

	typedef struct packed {
		logic [2:0][REM_W-1:0]     rem;
		logic [2:0][QUO_W-1:0]     quo;
		logic [LEN_W-1:0]          len;
		logic [2:0]                neg;
		logic                      short_axis;
	} div_pipe_t;

	logic [MAG_W-1:0]   mag_w [3];
	logic [MAG_W-1:0]   m_s1 [3];
	logic [SQ_W-1:0]    sq_s1 [3];
	logic [2:0]         neg_s1;
	logic [MAG_W-1:0]   m_s2 [3];
	logic [2:0]         neg_s2;
	logic [SHIFT_W-1:0] k_s2;
	logic               short_s2;
	logic [MAG_W-1:0]   mk_s3 [3];
	logic [SQ_W-1:0]    sq_s3 [3];
	logic [2:0]         neg_s3;
	logic               short_s3;
	logic [SQ_W-1:0]    l2_w;
	logic [MAG_W-1:0]   big_w;
	logic [SHIFT_W-1:0] top_w;
	logic [SHIFT_W-1:0] k_w;
	sqrt_pipe_t         sqrt_s [SQRT_STEPS+1];
	div_pipe_t          div_s [QUO_W+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_w[i] = axis[i][DATA_W-1] ? (~axis[i] + MAG_W'(1)) : axis[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i]   <= mag_w[i];
				sq_s1[i]  <= mag_w[i] * mag_w[i];
				neg_s1[i] <= axis[i][DATA_W-1];
			end
		end
	end

	// The shift brings the largest magnitude up to bit 30; a magnitude already at bit 30 or above is not shifted.
	always_comb begin
		l2_w  = sq_s1[0] + sq_s1[1] + sq_s1[2];
		big_w = m_s1[0];
		if (m_s1[1] > big_w) big_w = m_s1[1];
		if (m_s1[2] > big_w) big_w = m_s1[2];
		top_w = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (big_w[b]) top_w = SHIFT_W'(b);
		end
		k_w = (top_w >= SHIFT_W'(NORM_MSB)) ? '0 : SHIFT_W'(NORM_MSB) - top_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2     <= m_s1;
			neg_s2   <= neg_s1;
			k_s2     <= k_w;
			short_s2 <= (l2_w >> FRACTION_BITS) <= SQ_W'(thr);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mk_s3[i] <= m_s2[i] << k_s2;
				sq_s3[i] <= SQ_W'(m_s2[i] << k_s2) * SQ_W'(m_s2[i] << k_s2);
			end
			neg_s3   <= neg_s2;
			short_s3 <= short_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_s[0].n          <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			sqrt_s[0].res        <= '0;
			sqrt_s[0].mk         <= {mk_s3[2], mk_s3[1], mk_s3[0]};
			sqrt_s[0].neg        <= neg_s3;
			sqrt_s[0].short_axis <= short_s3;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (62 - 2 * j);
		sqrt_pipe_t nxt_w;
		logic [SQ_W-1:0] trial_w;

		always_comb begin
			nxt_w   = sqrt_s[j];
			trial_w = sqrt_s[j].res + BITV;
			if (sqrt_s[j].n >= trial_w) begin
				nxt_w.n   = sqrt_s[j].n - trial_w;
				nxt_w.res = (sqrt_s[j].res >> 1) + BITV;
			end else begin
				nxt_w.res = sqrt_s[j].res >> 1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) sqrt_s[j+1] <= nxt_w;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_s[0].rem[i] = {1'b0, sqrt_s[SQRT_STEPS].mk[i], 30'd0};
			div_s[0].quo[i] = '0;
		end
		div_s[0].len        = sqrt_s[SQRT_STEPS].res[LEN_W-1:0];
		div_s[0].neg        = sqrt_s[SQRT_STEPS].neg;
		div_s[0].short_axis = sqrt_s[SQRT_STEPS].short_axis;
	end

	// Restoring division, quotient bit 30 first; the quotient never exceeds 2^30.
	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int B = QUO_W - 1 - j;
		div_pipe_t nxt_w;
		logic [REM_W-1:0] trial_w;

		always_comb begin
			nxt_w   = div_s[j];
			trial_w = REM_W'(div_s[j].len) << B;
			for (int i = 0; i < 3; i++) begin
				if (div_s[j].rem[i] >= trial_w) begin
					nxt_w.rem[i] = div_s[j].rem[i] - trial_w;
					nxt_w.quo[i] = div_s[j].quo[i] | (QUO_W'(1) << B);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) div_s[j+1] <= nxt_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				unit_vec[i] <= div_s[QUO_W].neg[i] ? -$signed({1'b0, div_s[QUO_W].quo[i]})
				                                    : $signed({1'b0, div_s[QUO_W].quo[i]});
			end
			short_axis <= div_s[QUO_W].short_axis;
		end
	end

endmodule

`default_nettype wire

FILE: sv/qpr_half_angle.sv
// Half-angle cosine and sine: angle wrap by staged conditional subtraction,
// quadrant fold and a pipelined CORDIC in rotation mode. Uses qpr_pkg.
`default_nettype none

module qpr_half_angle import qpr_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [DATA_W-1:0] angle,
	output logic signed [TRIG_W-1:0]      cos_q30,
	output logic signed [TRIG_W-1:0]      sin_q30
);

	typedef struct packed {
		logic signed [TRIG_W-1:0] x;
		logic signed [TRIG_W-1:0] y;
		logic signed [Z_W-1:0]    z;
		logic                     neg;
	} cordic_pipe_t;

	logic [ANG_W-1:0] mod_s [MOD_STEPS+1];
	cordic_pipe_t     cd_s [CORDIC_STEPS+1];
	logic [ANG_W-1:0] zu_w;
	logic             fold_w;

	// An offset that is a multiple of 360 degrees makes the angle nonnegative.
	always_ff @(posedge clk) begin
		if (en) mod_s[0] <= ANG_W'(longint'(angle) + MOD_OFS);
	end

	for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
		localparam logic [ANG_W-1:0] TRIAL = ANG_W'(MOD_DEG << (MOD_STEPS - 1 - j));
		always_ff @(posedge clk) begin
			if (en) mod_s[j+1] <= (mod_s[j] >= TRIAL) ? mod_s[j] - TRIAL : mod_s[j];
		end
	end

	always_comb begin
		zu_w   = (mod_s[MOD_STEPS] << ZSHL) >> ZSHR;
		fold_w = zu_w > ANG_W'(DEG90_Q24);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s[0].x   <= CORDIC_GAIN;
			cd_s[0].y   <= '0;
			cd_s[0].z   <= $signed(zu_w) - (fold_w ? Z_W'(DEG180_Q24) : Z_W'(0));
			cd_s[0].neg <= fold_w;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [Z_W-1:0] ATAN = $signed({3'b000, ATAN_DEG_Q24[i]});
		cordic_pipe_t nxt_w;

		always_comb begin
			nxt_w = cd_s[i];
			if (!cd_s[i].z[Z_W-1]) begin
				nxt_w.x = cd_s[i].x - (cd_s[i].y >>> i);
				nxt_w.y = cd_s[i].y + (cd_s[i].x >>> i);
				nxt_w.z = cd_s[i].z - ATAN;
			end else begin
				nxt_w.x = cd_s[i].x + (cd_s[i].y >>> i);
				nxt_w.y = cd_s[i].y - (cd_s[i].x >>> i);
				nxt_w.z = cd_s[i].z + ATAN;
			end
		end

		always_ff @(posedge clk) begin
			if (en) cd_s[i+1] <= nxt_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q30 <= cd_s[CORDIC_STEPS].neg ? -cd_s[CORDIC_STEPS].x : cd_s[CORDIC_STEPS].x;
			sin_q30 <= cd_s[CORDIC_STEPS].neg ? -cd_s[CORDIC_STEPS].y : cd_s[CORDIC_STEPS].y;
		end
	end

endmodule

`default_nettype wire

FILE: sv/quaternion_point_rotator_unit.sv
// Quaternion point rotator, top level: input stage, alignment, Hamilton products,
// saturation and the output register with skid stage. Uses qpr_pkg, qpr_axis_unit, qpr_half_angle.
`default_nettype none

// Rotates a Q16.16 point about an arbitrary axis by an angle in degrees, one beat
// per clock while item_stall is low. The depth of the pipeline is set by the axis
// normalization, a 32-stage square root followed by a 31-stage divider, with the
// CORDIC running alongside. The pipeline advances as long as the skid stage behind
// the output register is empty, so item_stall, a registered flag, is set when the
// result side holds off a waiting result while another one arrives behind it. An
// axis whose squared length is at or below the threshold register passes the point
// through unchanged and flags axis_was_zero.

module quaternion_point_rotator_unit import qpr_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [DATA_W-1:0]        cfg_wr_data,
	input  wire logic                     item_valid,
	output logic                          item_stall,
	input  wire logic signed [DATA_W-1:0] point_x,
	input  wire logic signed [DATA_W-1:0] point_y,
	input  wire logic signed [DATA_W-1:0] point_z,
	input  wire logic signed [DATA_W-1:0] angle_degrees,
	input  wire logic signed [DATA_W-1:0] axis_x,
	input  wire logic signed [DATA_W-1:0] axis_y,
	input  wire logic signed [DATA_W-1:0] axis_z,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output logic signed [DATA_W-1:0]      rotated_x,
	output logic signed [DATA_W-1:0]      rotated_y,
	output logic signed [DATA_W-1:0]      rotated_z,
	output logic                          axis_was_zero
);

	localparam int V_W  = 33;
	localparam int P_W  = 34;
	localparam int T_W  = 36;
	localparam int RT_W = 38;
	localparam int R_W  = 41;
	localparam int PROD_W = 72;

	function automatic logic signed [PROD_W-1:0] round_q30(input logic signed [PROD_W-1:0] prod);
		return (prod + PROD_W'(64'sd536870912)) >>> 30;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [R_W-1:0] r);
		logic signed [DATA_W-1:0] res;
		if ((&r[R_W-1:DATA_W-1]) || !(|r[R_W-1:DATA_W-1])) res = r[DATA_W-1:0];
		else if (r[R_W-1]) res = {1'b1, {(DATA_W-1){1'b0}}};
		else res = {1'b0, {(DATA_W-1){1'b1}}};
		return res;
	endfunction

	logic [DATA_W-1:0]        thr_q;
	logic                     en;
	logic                     side_vld_s [AXIS_LAT+1];
	logic signed [DATA_W-1:0] side_pnt_s [AXIS_LAT+1][3];
	logic signed [DATA_W-1:0] ang_s1;
	logic signed [DATA_W-1:0] axis_s1 [3];
	logic signed [UNIT_W-1:0] unit_w [3];
	logic                     short_w;
	logic signed [TRIG_W-1:0] cos_w;
	logic signed [TRIG_W-1:0] sin_w;
	logic signed [TRIG_W-1:0] cos_d [ALIGN_LAT];
	logic signed [TRIG_W-1:0] sin_d [ALIGN_LAT];

	logic                     vld_s1m, vld_s2m, vld_s3m, vld_s4m, vld_s5m;
	logic                     zero_s1m, zero_s2m, zero_s3m, zero_s4m, zero_s5m;
	logic signed [DATA_W-1:0] pnt_s1m [3];
	logic signed [DATA_W-1:0] pnt_s2m [3];
	logic signed [DATA_W-1:0] pnt_s3m [3];
	logic signed [DATA_W-1:0] pnt_s4m [3];
	logic signed [TRIG_W-1:0] cos_s1m, cos_s2m, cos_s3m;
	logic signed [V_W-1:0]    v_s1m [3];
	logic signed [V_W-1:0]    v_s2m [3];
	logic signed [V_W-1:0]    v_s3m [3];
	logic signed [P_W-1:0]    cp_s2m [3];
	logic signed [P_W-1:0]    vpd_s2m [3];
	logic signed [P_W-1:0]    vpp_s2m [3];
	logic signed [P_W-1:0]    vpm_s2m [3];
	logic signed [T_W-1:0]    tw_s3m;
	logic signed [T_W-1:0]    tv_s3m [3];
	logic signed [RT_W-1:0]   vtw_s4m [3];
	logic signed [RT_W-1:0]   ct_s4m [3];
	logic signed [RT_W-1:0]   vtp_s4m [3];
	logic signed [RT_W-1:0]   vtm_s4m [3];
	logic signed [R_W-1:0]    r_w [3];
	logic signed [DATA_W-1:0] res_s5m [3];

	logic                     take_w;
	logic                     out_vld_q, skid_vld_q;
	logic signed [DATA_W-1:0] out_res_q [3];
	logic signed [DATA_W-1:0] skid_res_q [3];
	logic                     out_zero_q, skid_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= DATA_W'(1);
		else if (cfg_wr_en) thr_q <= cfg_wr_data;
	end

	// The whole pipeline moves whenever the skid stage is empty.
	assign en         = !skid_vld_q;
	assign item_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= AXIS_LAT; k++) side_vld_s[k] <= 1'b0;
		end else if (en) begin
			side_vld_s[0] <= item_valid;
			for (int k = 0; k < AXIS_LAT; k++) side_vld_s[k+1] <= side_vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_pnt_s[0][0] <= point_x;
			side_pnt_s[0][1] <= point_y;
			side_pnt_s[0][2] <= point_z;
			ang_s1           <= angle_degrees;
			axis_s1[0]       <= axis_x;
			axis_s1[1]       <= axis_y;
			axis_s1[2]       <= axis_z;
			for (int k = 0; k < AXIS_LAT; k++) side_pnt_s[k+1] <= side_pnt_s[k];
		end
	end

	qpr_axis_unit u_axis (
		.clk        (clk),
		.en         (en),
		.thr        (thr_q),
		.axis       (axis_s1),
		.unit_vec   (unit_w),
		.short_axis (short_w)
	);

	qpr_half_angle u_angle (
		.clk     (clk),
		.en      (en),
		.angle   (ang_s1),
		.cos_q30 (cos_w),
		.sin_q30 (sin_w)
	);

	// The trig results are ready earlier than the unit vector; hold them until it is.
	always_ff @(posedge clk) begin
		if (en) begin
			cos_d[0] <= cos_w;
			sin_d[0] <= sin_w;
			for (int k = 1; k < ALIGN_LAT; k++) begin
				cos_d[k] <= cos_d[k-1];
				sin_d[k] <= sin_d[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1m <= 1'b0;
			vld_s2m <= 1'b0;
			vld_s3m <= 1'b0;
			vld_s4m <= 1'b0;
			vld_s5m <= 1'b0;
		end else if (en) begin
			vld_s1m <= side_vld_s[AXIS_LAT];
			vld_s2m <= vld_s1m;
			vld_s3m <= vld_s2m;
			vld_s4m <= vld_s3m;
			vld_s5m <= vld_s4m;
		end
	end

	// Vector part of q: sin times the unit axis.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s1m[i] <= V_W'(round_q30(PROD_W'(sin_d[ALIGN_LAT-1]) * PROD_W'(unit_w[i])));
			end
			cos_s1m  <= cos_d[ALIGN_LAT-1];
			pnt_s1m  <= side_pnt_s[AXIS_LAT];
			zero_s1m <= short_w;
		end
	end

	// First Hamilton product, each term rounded on its own.
	for (genvar i = 0; i < 3; i++) begin : g_t_terms
		localparam int A = (i + 1) % 3;
		localparam int B = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				cp_s2m[i]  <= P_W'(round_q30(PROD_W'(cos_s1m) * PROD_W'(pnt_s1m[i])));
				vpd_s2m[i] <= P_W'(round_q30(PROD_W'(v_s1m[i]) * PROD_W'(pnt_s1m[i])));
				vpp_s2m[i] <= P_W'(round_q30(PROD_W'(v_s1m[A]) * PROD_W'(pnt_s1m[B])));
				vpm_s2m[i] <= P_W'(round_q30(PROD_W'(v_s1m[B]) * PROD_W'(pnt_s1m[A])));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2m    <= v_s1m;
			cos_s2m  <= cos_s1m;
			pnt_s2m  <= pnt_s1m;
			zero_s2m <= zero_s1m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tw_s3m <= -T_W'(vpd_s2m[0]) - T_W'(vpd_s2m[1]) - T_W'(vpd_s2m[2]);
			for (int i = 0; i < 3; i++) begin
				tv_s3m[i] <= T_W'(cp_s2m[i]) + T_W'(vpp_s2m[i]) - T_W'(vpm_s2m[i]);
			end
			v_s3m    <= v_s2m;
			cos_s3m  <= cos_s2m;
			pnt_s3m  <= pnt_s2m;
			zero_s3m <= zero_s2m;
		end
	end

	// Second Hamilton product with the conjugate; only the vector part is kept.
	for (genvar i = 0; i < 3; i++) begin : g_r_terms
		localparam int A = (i + 1) % 3;
		localparam int B = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				vtw_s4m[i] <= RT_W'(round_q30(PROD_W'(v_s3m[i]) * PROD_W'(tw_s3m)));
				ct_s4m[i]  <= RT_W'(round_q30(PROD_W'(cos_s3m) * PROD_W'(tv_s3m[i])));
				vtp_s4m[i] <= RT_W'(round_q30(PROD_W'(v_s3m[A]) * PROD_W'(tv_s3m[B])));
				vtm_s4m[i] <= RT_W'(round_q30(PROD_W'(v_s3m[B]) * PROD_W'(tv_s3m[A])));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pnt_s4m  <= pnt_s3m;
			zero_s4m <= zero_s3m;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			r_w[i] = R_W'(ct_s4m[i]) - R_W'(vtw_s4m[i]) + R_W'(vtp_s4m[i]) - R_W'(vtm_s4m[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				res_s5m[i] <= zero_s4m ? pnt_s4m[i] : sat32(r_w[i]);
			end
			zero_s5m <= zero_s4m;
		end
	end

	assign take_w = !out_vld_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take_w) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (take_w) begin
			out_vld_q <= vld_s5m;
		end else if (vld_s5m) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take_w) begin
				out_res_q  <= skid_res_q;
				out_zero_q <= skid_zero_q;
			end
		end else if (take_w) begin
			out_res_q  <= res_s5m;
			out_zero_q <= zero_s5m;
		end else begin
			skid_res_q  <= res_s5m;
			skid_zero_q <= zero_s5m;
		end
	end

	assign result_valid  = out_vld_q;
	assign rotated_x     = out_res_q[0];
	assign rotated_y     = out_res_q[1];
	assign rotated_z     = out_res_q[2];
	assign axis_was_zero = out_zero_q;

endmodule

`default_nettype wire
